FILE: rtl/growable_tag_free_list_core_macros.svh
// Assertion macros for the growable tag free list core.
// Each macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef GROWABLE_TAG_FREE_LIST_CORE_MACROS_SVH
`define GROWABLE_TAG_FREE_LIST_CORE_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define TGFL_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("tgfl: invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define TGFL_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tgfl: implication violated");

// The consequent holds in the cycle after the antecedent.
`define TGFL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tgfl: next-cycle implication violated");

`endif

FILE: rtl/tgfl_pkg.sv
// Shared types and constants for the growable tag free list core.
// Has no dependencies; every RTL module imports it.
`default_nettype none

package tgfl_pkg;

   // Fixed field widths of the request, response and register beats.
   localparam int TAG_W = 10;
   localparam int ID_W  = 64;
   localparam int CNT_W = 11;
   localparam int LF_W  = 9;
   localparam int ST_W  = 2;

   // Load factor after reset, one half in 1/256 units.
   localparam logic [LF_W-1:0] LF_RESET = 9'd128;

   // Command codes.
   localparam logic CMD_ASSIGN  = 1'b0;
   localparam logic CMD_RECLAIM = 1'b1;

   // Status codes.
   localparam logic [ST_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [ST_W-1:0] STATUS_NO_FREE   = 2'd1;
   localparam logic [ST_W-1:0] STATUS_NOT_USED  = 2'd2;
   localparam logic [ST_W-1:0] STATUS_OUT_RANGE = 2'd3;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_GROW,
      ST_POP,
      ST_POP_WR,
      ST_RCL_WR
   } tgfl_state_type;

   // Request beat.
   typedef struct packed {
      logic              cmd;
      logic [ID_W-1:0]   op_handle;
      logic [TAG_W-1:0]  tag;
   } tgfl_req_type;

   // Response beat.
   typedef struct packed {
      logic [TAG_W-1:0]  assigned_tag;
      logic [ID_W-1:0]   last_op_handle;
      logic [ST_W-1:0]   status;
      logic [CNT_W-1:0]  used_count;
      logic [CNT_W-1:0]  free_count;
      logic [CNT_W-1:0]  allocated_count;
   } tgfl_rsp_type;

   // Control from the sequencer to the free list.
   typedef struct packed {
      logic init_wr;
      logic push;
      logic pop;
   } tgfl_fl_ctl_type;

   // Write request to the tag table.
   typedef struct packed {
      logic              en;
      logic              used;
      logic [ID_W-1:0]   owner;
   } tgfl_tag_wr_type;

endpackage

`default_nettype wire

FILE: rtl/tgfl_free_list.sv
// Circular free list of tags held in a synchronous memory, with head, tail and fill count.
// Depends on tgfl_pkg for the control struct.
`default_nettype none

module tgfl_free_list import tgfl_pkg::*; #(
   parameter int MAX_TAGS     = 1024,
   parameter int INITIAL_TAGS = 64,
   localparam int TW    = $clog2(MAX_TAGS),
   localparam int CW    = $clog2(MAX_TAGS + 1),
   localparam int START = (INITIAL_TAGS > MAX_TAGS) ? MAX_TAGS : INITIAL_TAGS
) (
   input  logic            clock,
   input  logic            reset,
   input  tgfl_fl_ctl_type ctl,
   input  logic [TW-1:0]   init_idx,
   input  logic [TW-1:0]   push_tag,
   output logic [TW-1:0]   head_tag,
   output logic [CW-1:0]   free_total
);

   logic [TW-1:0] mem [MAX_TAGS];
   logic [TW-1:0] head_ff, head_in;
   logic [TW-1:0] tail_ff, tail_in;
   logic [CW-1:0] free_ff, free_in;
   logic [TW-1:0] rd_ff;
   logic          wr_en;
   logic [TW-1:0] wr_addr;
   logic [TW-1:0] wr_data;

   // During the clearing pass entry i receives tag i+1 for the initial tags.
   always_comb begin
      wr_en   = ctl.push || (ctl.init_wr && (init_idx < TW'(START - 1)));
      wr_addr = ctl.init_wr ? init_idx : tail_ff;
      wr_data = ctl.init_wr ? TW'(init_idx + 1'b1) : push_tag;
   end

   // Pointer and count updates; both pointers wrap at the last entry.
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      free_in = free_ff;
      if (ctl.pop) begin
         head_in = (head_ff == TW'(MAX_TAGS - 1)) ? '0 : TW'(head_ff + 1'b1);
      end
      if (ctl.push) begin
         tail_in = (tail_ff == TW'(MAX_TAGS - 1)) ? '0 : TW'(tail_ff + 1'b1);
      end
      if (ctl.push && !ctl.pop) begin
         free_in = CW'(free_ff + 1'b1);
      end else if (ctl.pop && !ctl.push) begin
         free_in = CW'(free_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= TW'(START - 1);
         free_ff <= CW'(START - 1);
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         free_ff <= free_in;
      end
   end

   // Memory write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Memory read port, always at the head of the list.
   always_ff @(posedge clock) begin
      rd_ff <= mem[head_ff];
   end

   assign head_tag   = rd_ff;
   assign free_total = free_ff;

endmodule

`default_nettype wire

FILE: rtl/tgfl_tag_table.sv
// Per-tag table of in-use flag and owner handle in one synchronous memory.
// Depends on tgfl_pkg for the write struct and field widths.
`default_nettype none

module tgfl_tag_table import tgfl_pkg::*; #(
   parameter int MAX_TAGS = 1024,
   localparam int TW = $clog2(MAX_TAGS)
) (
   input  logic            clock,
   input  logic            init_wr,
   input  logic [TW-1:0]   init_idx,
   input  tgfl_tag_wr_type wr,
   input  logic [TW-1:0]   wr_addr,
   input  logic [TW-1:0]   rd_addr,
   output logic            rd_used,
   output logic [ID_W-1:0] rd_owner
);

   logic [ID_W:0]  mem [MAX_TAGS];
   logic [ID_W:0]  rd_ff;
   logic           mem_we;
   logic [TW-1:0]  mem_addr;
   logic [ID_W:0]  mem_data;

   // The clearing pass drops the in-use flag of every entry.
   always_comb begin
      mem_we   = init_wr || wr.en;
      mem_addr = init_wr ? init_idx : wr_addr;
      mem_data = init_wr ? '0 : {wr.used, wr.owner};
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_ff <= mem[rd_addr];
   end

   assign rd_used  = rd_ff[ID_W];
   assign rd_owner = rd_ff[ID_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/growable_tag_free_list_core.sv
// Tag allocator top level: sequencer, counters, growth check and response register.
// Depends on tgfl_pkg, tgfl_free_list, tgfl_tag_table and the assertion macro header.
//
// After reset the block runs a clearing pass over all entries that loads the initial free
// tags and clears every in-use flag; req_ready stays low during it. After that an assign or a
// reclaim is accepted; its result goes to the skid register and then the output register.
// A request refused for an out-of-range tag or an empty free list writes its result at
// accept and leaves the sequencer idle. A request that reads memory keeps the sequencer
// busy, paced by the registered read of the free list or tag table memory followed by
// the write back. An assign that grows the tag range first pushes each new tag onto the
// free list and then waits for the head read to see the new head. A finished response
// waits in the output register while the next request is taken. The load factor
// register on the csr port is always ready and takes every csr beat.
`default_nettype none
`include "growable_tag_free_list_core_macros.svh"

module growable_tag_free_list_core import tgfl_pkg::*; #(
   parameter int MAX_TAGS     = 1024,
   parameter int INITIAL_TAGS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tgfl_req_type     req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tgfl_rsp_type     rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [LF_W-1:0]  csr_data
);

   localparam int TW    = $clog2(MAX_TAGS);
   localparam int CW    = $clog2(MAX_TAGS + 1);
   localparam int LW    = CW + 1;
   localparam int PW    = LF_W + CW;
   localparam int CMPW  = (CW > CNT_W) ? CW : CNT_W;
   localparam int START = (INITIAL_TAGS > MAX_TAGS) ? MAX_TAGS : INITIAL_TAGS;

   tgfl_state_type  state_ff, state_in;
   logic [TW-1:0]   init_ff, init_in;
   tgfl_req_type    item_ff, item_in;
   logic [CW-1:0]   in_use_ff, in_use_in;
   logic [CW-1:0]   range_ff, range_in;
   logic [CW-1:0]   lim_ff, lim_in;
   logic [LF_W-1:0] lf_ff, lf_in;
   tgfl_rsp_type    res_ff, res_in;
   logic            res_pend_ff, res_pend_in;
   tgfl_rsp_type    rsp_ff;
   logic            rsp_valid_ff, rsp_valid_in;

   tgfl_fl_ctl_type fl_ctl;
   logic [TW-1:0]   fl_push_tag;
   logic [TW-1:0]   fl_head_tag;
   logic [CW-1:0]   fl_free;
   tgfl_tag_wr_type tag_wr;
   logic [TW-1:0]   tag_wr_addr;
   logic [TW-1:0]   tag_rd_addr;
   logic            tag_rd_used;
   logic [ID_W-1:0] tag_rd_owner;

   logic            accept;
   logic            out_load;
   logic            grow_go;
   logic [PW-1:0]   used_scaled;
   logic [PW-1:0]   lf_product;
   logic [LW-1:0]   dbl_range;
   logic [LW-1:0]   lim_calc;
   logic [CMPW-1:0] req_tag_ext;
   logic [CMPW-1:0] item_tag_ext;
   logic            out_of_range;

   // Memories.
   tgfl_free_list #(
      .MAX_TAGS     (MAX_TAGS),
      .INITIAL_TAGS (INITIAL_TAGS)
   ) u_free_list (
      .clock      (clock),
      .reset      (reset),
      .ctl        (fl_ctl),
      .init_idx   (init_ff),
      .push_tag   (fl_push_tag),
      .head_tag   (fl_head_tag),
      .free_total (fl_free)
   );

   tgfl_tag_table #(
      .MAX_TAGS (MAX_TAGS)
   ) u_tag_table (
      .clock    (clock),
      .init_wr  (fl_ctl.init_wr),
      .init_idx (init_ff),
      .wr       (tag_wr),
      .wr_addr  (tag_wr_addr),
      .rd_addr  (tag_rd_addr),
      .rd_used  (tag_rd_used),
      .rd_owner (tag_rd_owner)
   );

   // Handshakes. A result waiting in the skid register moves out when the output is free.
   assign out_load  = res_pend_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (state_ff == ST_IDLE) && (!res_pend_ff || out_load);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Growth check: used * 256 against load factor * range, and the doubled range limit.
   always_comb begin
      used_scaled = PW'({in_use_ff, 8'd0});
      lf_product  = PW'(lf_ff) * PW'(range_ff);
      grow_go     = (used_scaled > lf_product) && (range_ff < CW'(MAX_TAGS));
      dbl_range   = {range_ff, 1'b0};
      lim_calc    = (dbl_range > LW'(MAX_TAGS)) ? LW'(MAX_TAGS) : dbl_range;
   end

   // Reclaim range check and table read address, taken straight from the request beat.
   always_comb begin
      req_tag_ext  = CMPW'(req_data.tag);
      item_tag_ext = CMPW'(item_ff.tag);
      out_of_range = (req_tag_ext >= CMPW'(range_ff)) || (req_tag_ext >= CMPW'(MAX_TAGS));
      tag_rd_addr  = req_tag_ext[TW-1:0];
   end

   // Sequencer: next state, memory commands and the result of each request.
   always_comb begin
      state_in    = state_ff;
      init_in     = init_ff;
      item_in     = item_ff;
      in_use_in   = in_use_ff;
      range_in    = range_ff;
      lim_in      = lim_ff;
      lf_in       = (csr_valid && csr_ready) ? csr_data : lf_ff;
      fl_ctl      = '0;
      fl_push_tag = '0;
      tag_wr      = '0;
      tag_wr_addr = '0;
      res_in      = res_ff;
      res_pend_in = out_load ? 1'b0 : res_pend_ff;

      case (state_ff)
         ST_INIT: begin
            fl_ctl.init_wr = 1'b1;
            init_in        = TW'(init_ff + 1'b1);
            if (init_ff == TW'(MAX_TAGS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               item_in = req_data;
               if (req_data.cmd == CMD_ASSIGN) begin
                  if (grow_go) begin
                     lim_in   = CW'(lim_calc);
                     state_in = ST_GROW;
                  end else if (fl_free == '0) begin
                     res_in.assigned_tag    = '0;
                     res_in.last_op_handle  = '0;
                     res_in.status          = STATUS_NO_FREE;
                     res_in.used_count      = CNT_W'(in_use_ff);
                     res_in.free_count      = CNT_W'(fl_free);
                     res_in.allocated_count = CNT_W'(range_ff);
                     res_pend_in            = 1'b1;
                  end else begin
                     state_in = ST_POP_WR;
                  end
               end else begin
                  if (out_of_range) begin
                     res_in.assigned_tag    = '0;
                     res_in.last_op_handle  = '0;
                     res_in.status          = STATUS_OUT_RANGE;
                     res_in.used_count      = CNT_W'(in_use_ff);
                     res_in.free_count      = CNT_W'(fl_free);
                     res_in.allocated_count = CNT_W'(range_ff);
                     res_pend_in            = 1'b1;
                  end else begin
                     state_in = ST_RCL_WR;
                  end
               end
            end
         end
         ST_GROW: begin
            // The range counter doubles as the next new tag to push.
            fl_ctl.push = 1'b1;
            fl_push_tag = range_ff[TW-1:0];
            range_in    = CW'(range_ff + 1'b1);
            if (CW'(range_ff + 1'b1) == lim_ff) begin
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            // Lets the head read see the last pushed tag.
            state_in = ST_POP_WR;
         end
         ST_POP_WR: begin
            fl_ctl.pop             = 1'b1;
            tag_wr.en              = 1'b1;
            tag_wr.used            = 1'b1;
            tag_wr.owner           = item_ff.op_handle;
            tag_wr_addr            = fl_head_tag;
            in_use_in              = CW'(in_use_ff + 1'b1);
            res_in.assigned_tag    = TAG_W'(fl_head_tag);
            res_in.last_op_handle  = '0;
            res_in.status          = STATUS_OK;
            res_in.used_count      = CNT_W'(CW'(in_use_ff + 1'b1));
            res_in.free_count      = CNT_W'(CW'(fl_free - 1'b1));
            res_in.allocated_count = CNT_W'(range_ff);
            res_pend_in            = 1'b1;
            state_in               = ST_IDLE;
         end
         ST_RCL_WR: begin
            res_in.assigned_tag    = '0;
            res_in.allocated_count = CNT_W'(range_ff);
            if (tag_rd_used) begin
               tag_wr.en             = 1'b1;
               tag_wr.used           = 1'b0;
               tag_wr.owner          = tag_rd_owner;
               tag_wr_addr           = item_tag_ext[TW-1:0];
               fl_ctl.push           = 1'b1;
               fl_push_tag           = item_tag_ext[TW-1:0];
               in_use_in             = CW'(in_use_ff - 1'b1);
               res_in.last_op_handle = tag_rd_owner;
               res_in.status         = STATUS_OK;
               res_in.used_count     = CNT_W'(CW'(in_use_ff - 1'b1));
               res_in.free_count     = CNT_W'(CW'(fl_free + 1'b1));
            end else begin
               res_in.last_op_handle = '0;
               res_in.status         = STATUS_NOT_USED;
               res_in.used_count     = CNT_W'(in_use_ff);
               res_in.free_count     = CNT_W'(fl_free);
            end
            res_pend_in = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register valid.
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_ff      <= '0;
         in_use_ff    <= '0;
         range_ff     <= CW'(START);
         lim_ff       <= CW'(START);
         lf_ff        <= LF_RESET;
         res_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         in_use_ff    <= in_use_in;
         range_ff     <= range_in;
         lim_ff       <= lim_in;
         lf_ff        <= lf_in;
         res_pend_ff  <= res_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      res_ff  <= res_in;
      if (out_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Every tag other than the reserved one is either free or in use.
   `TGFL_ASSERT_ALWAYS(a_tag_balance, (LW'(fl_free) + LW'(in_use_ff)) == LW'(range_ff - 1'b1))
   // The allocated range never passes the maximum.
   `TGFL_ASSERT_ALWAYS(a_range_max, range_ff <= CW'(MAX_TAGS))
   // Growth only runs while new tags remain below the limit.
   `TGFL_ASSERT_IMPL(a_grow_limit, state_ff == ST_GROW, range_ff < lim_ff)
   // An accepted request either keeps the sequencer busy or has left a result.
   `TGFL_ASSERT_NEXT(a_accept_progress, accept, (state_ff != ST_IDLE) || res_pend_ff)

endmodule

`default_nettype wire
